// ===== rtl/hasi_pkg.sv =====
// Shared types and constants of the hashed address set.
package hasi_pkg;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 12;
    localparam int COUNT_W = 12;

    localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

    typedef enum logic [1:0] {
        ST_NEW      = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PS_CLEAR,
        PS_IDLE,
        PS_READ,
        PS_CHECK,
        PS_DONE
    } probe_state_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot_index;
        logic [COUNT_W-1:0]   entry_count;
    } result_t;

endpackage

// ===== rtl/hasi_key_if.sv =====
// Key channel: valid, ready and one 32-bit address.
interface hasi_key_if
    import hasi_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

// ===== rtl/hasi_result_if.sv =====
// Result channel: valid, ready, status, slot and entry count.
interface hasi_result_if
    import hasi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output slot_index, output entry_count,
                    input ready);
    modport sink (input valid, input status, input slot_index, input entry_count,
                  output ready);
endinterface

// ===== rtl/hasi_slot_ram.sv =====
// Slot store: one write port, one read port with registered read data.
module hasi_slot_ram
    import hasi_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [KEY_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [KEY_W-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hasi_probe_seq.sv =====
// Probe sequencer: clear pass, hash, linear probe loop and insert decision.
module hasi_probe_seq
    import hasi_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    hasi_key_if.sink      key_ch,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] LOAD_LIMIT = IDX_W'(TABLE_SLOTS * 3 / 4);

    probe_state_t     state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0] held_reg, held_next;
    logic [KEY_W-1:0] key_reg, key_next;
    result_t          res_reg, res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic             ram_re;
    logic [KEY_W-1:0] ram_rdata;

    logic [IDX_W-1:0]   hash_prod;
    logic               slot_empty;
    logic               slot_match;
    logic               last_probe;

    function automatic logic [SLOT_W-1:0] to_field(logic [IDX_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[SLOT_W-1:0];
    endfunction

    // Only the low index bits of the 32-bit product matter.
    assign hash_prod  = key_ch.key[IDX_W+1:2] * HASH_MULT[IDX_W-1:0];
    assign slot_empty = (ram_rdata == '0);
    assign slot_match = (ram_rdata == key_reg);
    assign last_probe = (probe_cnt_reg == '1);

    hasi_slot_ram #(
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PS_CLEAR:
            begin
                if (addr_reg == '1)
                begin
                    state_next = PS_IDLE;
                end
            end
            PS_IDLE:
            begin
                if (key_ch.valid)
                begin
                    state_next = (key_ch.key == '0) ? PS_DONE : PS_READ;
                end
            end
            PS_READ:
            begin
                state_next = PS_CHECK;
            end
            PS_CHECK:
            begin
                if (slot_empty || slot_match || last_probe)
                begin
                    state_next = PS_DONE;
                end
                else
                begin
                    state_next = PS_READ;
                end
            end
            PS_DONE:
            begin
                if (res_ready)
                begin
                    state_next = PS_IDLE;
                end
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        addr_next      = addr_reg;
        probe_cnt_next = probe_cnt_reg;
        held_next      = held_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = key_reg;
        ram_re         = 1'b0;
        key_ch.ready   = 1'b0;
        res_valid      = 1'b0;
        unique case (state_reg)
            PS_CLEAR:
            begin
                // Zero one slot a cycle; the index wraps back to zero at the end.
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = addr_reg + 1'b1;
            end
            PS_IDLE:
            begin
                key_ch.ready = 1'b1;
                if (key_ch.valid)
                begin
                    key_next       = key_ch.key;
                    addr_next      = hash_prod;
                    probe_cnt_next = '0;
                    res_next.status      = ST_RESERVED;
                    res_next.slot_index  = '0;
                    res_next.entry_count = to_field(held_reg);
                end
            end
            PS_READ:
            begin
                ram_re = 1'b1;
            end
            PS_CHECK:
            begin
                priority if (slot_empty)
                begin
                    if (held_reg >= LOAD_LIMIT)
                    begin
                        res_next.status      = ST_FULL;
                        res_next.slot_index  = '0;
                        res_next.entry_count = to_field(held_reg);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        held_next = held_reg + 1'b1;
                        res_next.status      = ST_NEW;
                        res_next.slot_index  = to_field(addr_reg);
                        res_next.entry_count = to_field(held_reg + 1'b1);
                    end
                end
                else if (slot_match)
                begin
                    res_next.status      = ST_PRESENT;
                    res_next.slot_index  = to_field(addr_reg);
                    res_next.entry_count = to_field(held_reg);
                end
                else if (last_probe)
                begin
                    res_next.status      = ST_FULL;
                    res_next.slot_index  = '0;
                    res_next.entry_count = to_field(held_reg);
                end
                else
                begin
                    // Advance to the next slot, wrapping at the table end.
                    addr_next      = addr_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            PS_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_CLEAR;
            addr_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_cnt_reg <= probe_cnt_next;
        key_reg       <= key_next;
        res_reg       <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/hashed_address_set_insert_top.sv =====
// Top level of the hashed address set: probe sequencer and result register.
//
//  channel     role   payload                               transfer
//  key_ch      sink   key[31:0]                             valid && ready
//  result_ch   source status[1:0] slot_index[11:0]          valid && ready
//                     entry_count[11:0]
//
// A zero key goes from IDLE straight to DONE without a slot store read; a key that ends
// on probe n passes READ and CHECK once per probe, through the one RAM read port.
// From DONE the sequencer returns to IDLE before the next transfer, so it takes no new
// key until the result of the last one has left DONE.
// After reset a clearing pass zeroes every slot of the slot store, and
// key_ch.ready stays low until it ends.
// A key is taken while an earlier result still waits in the result register;
// its own result waits in the sequencer until that register frees up.
module hashed_address_set_insert_top
    import hasi_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    hasi_key_if.sink     key_ch,
    hasi_result_if.source result_ch
);

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;

    hasi_probe_seq #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_probe (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_ch    (key_ch),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || result_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        priority if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.status      = out_res_reg.status;
    assign result_ch.slot_index  = out_res_reg.slot_index;
    assign result_ch.entry_count = out_res_reg.entry_count;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the hashed address set: directed, random, back-to-back keys.
module tb_top;
    import hasi_pkg::*;

    localparam int TABLE_SLOTS  = 4096;
    localparam int RANDOM_KEYS  = 1150;
    localparam int BURST_KEYS   = 150;
    localparam int FULL_KEYS    = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam logic [KEY_W-1:0] GOLDEN_MULT = 32'd2654435761;

    // Set model, expected results and result checks.
    class set_scoreboard;
        logic [KEY_W-1:0] slots [TABLE_SLOTS];
        int unsigned      held;
        logic [KEY_W-1:0] kept_keys [$];
        result_t          expected_q [$];
        int unsigned      errors;
        int unsigned      by_status [4];

        function new();
            foreach (slots[i]) slots[i] = '0;
            foreach (by_status[i]) by_status[i] = 0;
            held   = 0;
            errors = 0;
        endfunction

        function int unsigned home_slot(logic [KEY_W-1:0] k);
            logic [KEY_W-1:0] h;
            h = (k >> 2) * GOLDEN_MULT;
            return h & (TABLE_SLOTS - 1);
        endfunction

        function result_t insert_key(logic [KEY_W-1:0] k);
            result_t     r;
            int unsigned j;
            bit          open_slot;
            open_slot    = 1'b0;
            r.status     = ST_FULL;
            r.slot_index = '0;
            if (k == '0)
            begin
                r.status      = ST_RESERVED;
                r.entry_count = held[COUNT_W-1:0];
                return r;
            end
            j = home_slot(k);
            for (int n = 0; n < TABLE_SLOTS; n++)
            begin
                if (slots[j] == '0)
                begin
                    open_slot = 1'b1;
                    break;
                end
                if (slots[j] == k)
                begin
                    r.status      = ST_PRESENT;
                    r.slot_index  = j[SLOT_W-1:0];
                    r.entry_count = held[COUNT_W-1:0];
                    return r;
                end
                j = (j + 1) % TABLE_SLOTS;
            end
            // Store only while the load stays within three quarters.
            if (open_slot && (held + 1) * 4 <= TABLE_SLOTS * 3)
            begin
                slots[j] = k;
                held++;
                kept_keys.push_back(k);
                r.status     = ST_NEW;
                r.slot_index = j[SLOT_W-1:0];
            end
            r.entry_count = held[COUNT_W-1:0];
            return r;
        endfunction

        function void note_key(logic [KEY_W-1:0] k);
            result_t r;
            r = insert_key(k);
            expected_q.push_back(r);
            by_status[r.status]++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 30)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(input logic [1:0] st, input logic [SLOT_W-1:0] sl,
                          input logic [COUNT_W-1:0] cnt);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending: status %0d slot %0d count %0d",
                                 st, sl, cnt));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.status || sl !== want.slot_index || cnt !== want.entry_count)
                report($sformatf("status %0d/%0d slot %0d/%0d count %0d/%0d (got/want)",
                                 st, want.status, sl, want.slot_index,
                                 cnt, want.entry_count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    bit   hold_rx;
    int unsigned cycles;
    int unsigned sent;

    set_scoreboard sb = new();

    hasi_key_if    key_ch ();
    hasi_result_if result_ch ();

    hashed_address_set_insert_top #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_ch    (key_ch),
        .result_ch (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results pending", CYCLE_LIMIT, sb.pending());
        $display("hashed_address_set_insert_top: mismatch");
        $finish;
    end

    // Result side: check each transfer, then pick ready for the next edge.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.status, result_ch.slot_index,
                                result_ch.entry_count);
            result_ch.ready <= !hold_rx && (!idle_on || $urandom_range(99) >= 34);
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] k);
        int gap;
        gap = 0;
        if (idle_on)
        begin
            while ($urandom_range(99) < 34)
                gap++;
            if ($urandom_range(99) < 3)
                gap += $urandom_range(30, 5);
        end
        if (gap > 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key   <= k;
        do
            @(posedge clk);
        while (!key_ch.ready);
        sb.note_key(k);
        sent++;
    endtask

    // Drop valid and hold until every pending result has been checked.
    task automatic wait_drained();
        key_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] key_with_home(int unsigned target);
        for (int unsigned m = 0; m < TABLE_SLOTS; m++)
            if (sb.home_slot(m << 2) == target)
                return m << 2;
        return '0;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        int unsigned roll;
        int unsigned n;
        logic [KEY_W-1:0] base;
        roll = $urandom_range(99);
        n    = sb.kept_keys.size();
        if (roll < 5)
            return '0;
        if (n == 0 || roll < 60)
            return $urandom;
        base = sb.kept_keys[$urandom_range(n - 1)];
        if (roll < 85)
            return base;
        // Same home slot: step by the table size above the two dropped bits.
        if (roll < 93)
            return base + 32'd16384 * $urandom_range(40, 1);
        return base ^ $urandom_range(3, 1);
    endfunction

    initial
    begin
        logic [KEY_W-1:0] wrap_key;
        int unsigned      zero_keys;
        rst_n        <= 1'b0;
        key_ch.valid <= 1'b0;
        key_ch.key   <= '0;
        hold_rx      <= 1'b0;
        idle_on   = 1'b1;
        zero_keys = 0;
        sent      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, collisions in slot zero, wrap past the last slot.
        wrap_key = key_with_home(TABLE_SLOTS - 1);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0001);
        send_key(32'h0000_0002);
        send_key(32'h0000_0003);
        send_key(32'h8000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0001);
        send_key(wrap_key);
        send_key(wrap_key + 32'd1);
        send_key(wrap_key + 32'd2);
        send_key(wrap_key + 32'd3);
        send_key(wrap_key + 32'd2);
        send_key(wrap_key + 32'd16384);
        send_key(32'hAAAA_AAAA);
        send_key(32'h5555_5555);
        send_key(32'h0000_0000);
        send_key(wrap_key + 32'd16384);
        zero_keys += 2;
        wait_drained();

        // Random mix at low and medium load.
        for (int i = 0; i < RANDOM_KEYS; i++)
        begin
            logic [KEY_W-1:0] k;
            k = random_key();
            if (k == '0)
                zero_keys++;
            if (i == 300)
            begin
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end
            if (i == 800)
                wait_drained();
            send_key(k);
        end
        wait_drained();

        // Back-to-back new keys with no idling on either side.
        idle_on = 1'b0;
        for (int i = 0; i < BURST_KEYS; i++)
            send_key($urandom | 32'h1);
        wait_drained();

        // Mixed keys again with idling back on.
        idle_on = 1'b1;
        for (int i = 0; i < FULL_KEYS; i++)
        begin
            logic [KEY_W-1:0] k;
            k = random_key();
            if (k == '0)
                zero_keys++;
            send_key(k);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d keys (%0d zero) in %0d cycles; load reached %0d of %0d slots.",
                 sent, zero_keys, cycles, sb.held, TABLE_SLOTS);
        $display("Outcomes: %0d new, %0d present, %0d full, %0d reserved; %0d mismatches.",
                 sb.by_status[ST_NEW], sb.by_status[ST_PRESENT], sb.by_status[ST_FULL],
                 sb.by_status[ST_RESERVED], sb.errors);
        if (sb.errors == 0)
            $display("hashed_address_set_insert_top: match");
        else
            $display("hashed_address_set_insert_top: mismatch");
        $finish;
    end

endmodule
